### sv/pls_pkg.sv
// Package for the positional list store: operation and status codes, sequencer types
// and the default capacity.
// No dependencies; the top level and the test files import it.
package pls_pkg;

  // Default number of entries the store can hold.
  localparam int unsigned DEF_CAPACITY = 64;

  // Field widths fixed by the item format.
  localparam int unsigned OP_W     = 3;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned OCOUNT_W = 7;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_INS_POS   = 3'd2;
  localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd3;
  localparam logic [OP_W-1:0] OP_DEL_BACK  = 3'd4;
  localparam logic [OP_W-1:0] OP_DEL_POS   = 3'd5;
  localparam logic [OP_W-1:0] OP_DEL_VAL   = 3'd6;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STS_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] STS_INVALID  = 3'd1;
  localparam logic [STATUS_W-1:0] STS_EMPTY    = 3'd2;
  localparam logic [STATUS_W-1:0] STS_OOB      = 3'd3;
  localparam logic [STATUS_W-1:0] STS_NOTFOUND = 3'd4;
  localparam logic [STATUS_W-1:0] STS_FULL     = 3'd5;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_UP,
    S_DOWN,
    S_SEARCH
  } state_t;

  // What the decoder decides to do with an accepted item.
  typedef enum logic [2:0] {
    ACT_REPORT,
    ACT_PUT,
    ACT_DROP,
    ACT_SHIFT_UP,
    ACT_SHIFT_DOWN,
    ACT_SEARCH
  } act_t;

endpackage

### sv/pls_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; used as the entry store of the positional list store.
module pls_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### sv/positional_list_store.sv
// Top level of the positional list store: decoder, shift/search sequencer and result register.
// Depends on pls_pkg and on pls_ram for the entry store.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid, in_stall, in_operation,       | request
//          | in_position, in_value                   |
//  out     | out_valid, out_stall, out_status,       | result
//          | out_item_count                          |
//
// A request that needs no moves (errors, insert at the back end, delete of the last entry)
// has its result registered on the edge at which the item is accepted. A shifting insert or
// delete moves one entry a cycle through the single RAM port pair; a delete by value scans one
// entry a cycle up to the first match and then shifts the entries after it. Reset clears the
// entry count; the RAM is not cleared.
// No new item is taken while a request is in progress or while a result is stalled.
module positional_list_store
  import pls_pkg::*;
#(
  parameter int unsigned CAPACITY = DEF_CAPACITY
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [OP_W-1:0]             in_operation,
  input  logic [POS_W-1:0]            in_position,
  input  logic signed [VAL_W-1:0]     in_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [STATUS_W-1:0]         out_status,
  output logic [OCOUNT_W-1:0]         out_item_count
);

  localparam int unsigned IDX_W   = $clog2(CAPACITY);
  localparam int unsigned COUNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W   = ((COUNT_W > POS_W) ? COUNT_W : POS_W) + 1;

  // Sequencer and datapath registers.
  state_t               state_r, state_nxt;
  logic [COUNT_W-1:0]   cnt_r, cnt_nxt;
  logic [IDX_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [IDX_W-1:0]     q_r, q_nxt;
  logic [IDX_W-1:0]     lim_r, lim_nxt;
  logic                 rd_more_r, rd_more_nxt;
  logic                 rdv_r, rdv_nxt;
  logic [VAL_W-1:0]     val_r, val_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [OCOUNT_W-1:0]  out_count_r, out_count_nxt;

  // RAM port signals.
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [VAL_W-1:0]     ram_wdata;
  logic [VAL_W-1:0]     ram_rdata;

  // Decoder results.
  act_t                 dec_act;
  logic [STATUS_W-1:0]  dec_status;
  logic [IDX_W-1:0]     dec_idx;

  logic                 accept;
  logic                 full;
  logic                 empty;
  logic [IDX_W-1:0]     cnt_idx;
  logic [IDX_W-1:0]     last_idx;
  logic [CMP_W-1:0]     pos_x;
  logic [CMP_W-1:0]     cnt_x;
  logic [CMP_W-1:0]     pos_m1;
  logic                 match;
  logic                 at_last;
  logic                 drained;
  logic [COUNT_W+OCOUNT_W-1:0] count_ext;

  pls_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_ptr_r),
    .rdata (ram_rdata)
  );

  // Handshake and common status of the store.
  assign in_stall = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;
  assign full     = (cnt_r == COUNT_W'(CAPACITY));
  assign empty    = (cnt_r == '0);
  assign cnt_idx  = IDX_W'(cnt_r);
  assign last_idx = IDX_W'(cnt_r - 1'b1);
  assign pos_x    = CMP_W'(in_position);
  assign cnt_x    = CMP_W'(cnt_r);
  assign pos_m1   = pos_x - 1'b1;

  // The shared compare unit and the sequencer's end conditions.
  assign match   = rdv_r && (ram_rdata == val_r);
  assign at_last = (q_r == lim_r);
  assign drained = !rd_more_r && !rdv_r;

  // Request decoder: checks in the order the behaviour defines, then picks the action.
  always_comb begin
    dec_act    = ACT_REPORT;
    dec_status = STS_INVALID;
    dec_idx    = '0;
    unique case (in_operation) inside
      OP_INS_FRONT, OP_INS_BACK, OP_INS_POS: begin
        if (in_operation == OP_INS_BACK) begin
          dec_idx = cnt_idx;
        end else if (in_operation == OP_INS_POS) begin
          dec_idx = pos_m1[IDX_W-1:0];
        end
        if ((in_operation == OP_INS_POS) && (in_position == '0)) begin
          dec_status = STS_INVALID;
        end else if ((in_operation == OP_INS_POS) && (pos_x > cnt_x + 1'b1)) begin
          dec_status = STS_OOB;
        end else if (full) begin
          dec_status = STS_FULL;
        end else begin
          dec_status = STS_OK;
          dec_act    = (dec_idx == cnt_idx) ? ACT_PUT : ACT_SHIFT_UP;
        end
      end
      OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_POS, OP_DEL_VAL: begin
        if (in_operation == OP_DEL_BACK) begin
          dec_idx = last_idx;
        end else if (in_operation == OP_DEL_POS) begin
          dec_idx = pos_m1[IDX_W-1:0];
        end
        if (empty) begin
          dec_status = STS_EMPTY;
        end else if ((in_operation == OP_DEL_POS) && (in_position == '0)) begin
          dec_status = STS_INVALID;
        end else if ((in_operation == OP_DEL_POS) && (pos_x > cnt_x)) begin
          dec_status = STS_OOB;
        end else if (in_operation == OP_DEL_VAL) begin
          dec_status = STS_NOTFOUND;
          dec_act    = ACT_SEARCH;
        end else begin
          dec_status = STS_OK;
          dec_act    = (dec_idx == last_idx) ? ACT_DROP : ACT_SHIFT_DOWN;
        end
      end
      default: begin
        dec_status = STS_INVALID;
      end
    endcase
  end

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (dec_act == ACT_SHIFT_UP) begin
            state_nxt = S_UP;
          end else if (dec_act == ACT_SHIFT_DOWN) begin
            state_nxt = S_DOWN;
          end else if (dec_act == ACT_SEARCH) begin
            state_nxt = S_SEARCH;
          end
        end
      end
      S_UP, S_DOWN: begin
        if (drained) begin
          state_nxt = S_IDLE;
        end
      end
      S_SEARCH: begin
        if (match && !at_last) begin
          state_nxt = S_DOWN;
        end else if (rdv_r && at_last) begin
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  // Datapath, RAM controls and result register.
  always_comb begin
    cnt_nxt        = cnt_r;
    rd_ptr_nxt     = rd_ptr_r;
    q_nxt          = q_r;
    lim_nxt        = lim_r;
    rd_more_nxt    = rd_more_r;
    rdv_nxt        = 1'b0;
    val_nxt        = val_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    ram_we         = 1'b0;
    ram_waddr      = q_r;
    ram_wdata      = ram_rdata;

    // Read pipeline: issue one read a cycle until the last address of the run.
    if ((state_r != S_IDLE) && rd_more_r) begin
      rdv_nxt = 1'b1;
      q_nxt   = rd_ptr_r;
      if (rd_ptr_r == lim_r) begin
        rd_more_nxt = 1'b0;
      end else if (state_r == S_UP) begin
        rd_ptr_nxt = rd_ptr_r - 1'b1;
      end else begin
        rd_ptr_nxt = rd_ptr_r + 1'b1;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          val_nxt = in_value;
          unique case (dec_act)
            ACT_PUT: begin
              ram_we    = 1'b1;
              ram_waddr = dec_idx;
              ram_wdata = in_value;
              cnt_nxt   = cnt_r + 1'b1;
            end
            ACT_DROP: begin
              cnt_nxt = cnt_r - 1'b1;
            end
            ACT_SHIFT_UP: begin
              rd_ptr_nxt  = last_idx;
              lim_nxt     = dec_idx;
              rd_more_nxt = 1'b1;
            end
            ACT_SHIFT_DOWN: begin
              rd_ptr_nxt  = dec_idx + 1'b1;
              lim_nxt     = last_idx;
              rd_more_nxt = 1'b1;
            end
            ACT_SEARCH: begin
              rd_ptr_nxt  = '0;
              lim_nxt     = last_idx;
              rd_more_nxt = 1'b1;
            end
            default: begin
            end
          endcase
          if ((dec_act == ACT_REPORT) || (dec_act == ACT_PUT) || (dec_act == ACT_DROP)) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = dec_status;
          end
        end
      end
      S_UP: begin
        // Move the entry read last cycle one place back, then place the new value.
        if (rdv_r) begin
          ram_we    = 1'b1;
          ram_waddr = q_r + 1'b1;
        end else if (!rd_more_r) begin
          ram_we         = 1'b1;
          ram_waddr      = lim_r;
          ram_wdata      = val_r;
          cnt_nxt        = cnt_r + 1'b1;
          out_valid_nxt  = 1'b1;
          out_status_nxt = STS_OK;
        end
      end
      S_DOWN: begin
        // Move the entry read last cycle one place forward over the gap.
        if (rdv_r) begin
          ram_we    = 1'b1;
          ram_waddr = q_r - 1'b1;
        end else if (!rd_more_r) begin
          cnt_nxt        = cnt_r - 1'b1;
          out_valid_nxt  = 1'b1;
          out_status_nxt = STS_OK;
        end
      end
      S_SEARCH: begin
        if (match && !at_last) begin
          // Found inside the list: restart the reads for the closing shift.
          rd_ptr_nxt  = q_r + 1'b1;
          rd_more_nxt = 1'b1;
          rdv_nxt     = 1'b0;
        end else if (match) begin
          cnt_nxt        = cnt_r - 1'b1;
          out_valid_nxt  = 1'b1;
          out_status_nxt = STS_OK;
        end else if (rdv_r && at_last) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STS_NOTFOUND;
        end
      end
    endcase

    count_ext     = {{OCOUNT_W{1'b0}}, cnt_nxt};
    out_count_nxt = out_valid_nxt && !(out_valid_r && out_stall)
                    ? count_ext[OCOUNT_W-1:0] : out_count_r;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      rd_more_r   <= 1'b0;
      rdv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rd_more_r   <= rd_more_nxt;
      rdv_r       <= rdv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    rd_ptr_r     <= rd_ptr_nxt;
    q_r          <= q_nxt;
    lim_r        <= lim_nxt;
    val_r        <= val_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_item_count = out_count_r;

endmodule

### test/pls_result_checker.sv
// Result checker for the positional list store: watches both item channels, keeps its own
// copy of the list, predicts each result and compares it field by field.
// Depends on pls_pkg for field widths, operation codes and status codes.
`timescale 1ns / 100ps

module pls_result_checker
  import pls_pkg::*;
#(
  parameter int unsigned CAPACITY = DEF_CAPACITY
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic [OP_W-1:0]         in_operation,
  input  logic [POS_W-1:0]        in_position,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic [STATUS_W-1:0]     out_status,
  input  logic [OCOUNT_W-1:0]     out_item_count,
  output int                      mismatch_count,
  output int                      results_owed,
  output int                      list_length
);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OCOUNT_W-1:0] item_count;
  } list_result_t;

  logic signed [VAL_W-1:0] held_values [CAPACITY];
  int unsigned             held_len;
  list_result_t            due_results [$];
  int                      errors;

  task automatic report_mismatch(input string what);
    errors++;
    $display("%0t ns: mismatch: %s", $time, what);
  endtask

  // Put a value at index idx, moving the later entries back by one.
  function automatic logic [STATUS_W-1:0] insert_entry(input int unsigned idx,
                                                       input logic signed [VAL_W-1:0] v);
    if (held_len >= CAPACITY) return STS_FULL;
    if (idx > held_len) return STS_OOB;
    for (int unsigned k = held_len; k > idx; k--) begin
      held_values[k] = held_values[k-1];
    end
    held_values[idx] = v;
    held_len++;
    return STS_OK;
  endfunction

  // Remove the entry at index idx and close the gap.
  function automatic logic [STATUS_W-1:0] remove_entry(input int unsigned idx);
    if (held_len == 0) return STS_EMPTY;
    if (idx >= held_len) return STS_OOB;
    for (int unsigned k = idx; k + 1 < held_len; k++) begin
      held_values[k] = held_values[k+1];
    end
    held_len--;
    return STS_OK;
  endfunction

  // Apply one request to the held list and return the status it reports.
  function automatic logic [STATUS_W-1:0] apply_request(input logic [OP_W-1:0] op,
                                                        input logic [POS_W-1:0] pos,
                                                        input logic signed [VAL_W-1:0] v);
    logic [STATUS_W-1:0] st;
    int unsigned         p;
    st = STS_INVALID;
    p  = 32'(pos);
    case (op)
      OP_INS_FRONT: st = insert_entry(0, v);
      OP_INS_BACK:  st = insert_entry(held_len, v);
      OP_INS_POS: begin
        // Position checks come before the full check.
        if (p == 0) st = STS_INVALID;
        else if (p - 1 > held_len) st = STS_OOB;
        else st = insert_entry(p - 1, v);
      end
      OP_DEL_FRONT: st = remove_entry(0);
      OP_DEL_BACK:  st = (held_len == 0) ? STS_EMPTY : remove_entry(held_len - 1);
      OP_DEL_POS: begin
        // An empty list is reported before any position check.
        if (held_len == 0) st = STS_EMPTY;
        else if (p == 0) st = STS_INVALID;
        else st = remove_entry(p - 1);
      end
      OP_DEL_VAL: begin
        if (held_len == 0) begin
          st = STS_EMPTY;
        end else begin
          st = STS_NOTFOUND;
          for (int unsigned k = 0; k < held_len; k++) begin
            if (held_values[k] == v) begin
              st = remove_entry(k);
              break;
            end
          end
        end
      end
      default: st = STS_INVALID;
    endcase
    return st;
  endfunction

  // Compare accepted results first, then predict for an item accepted on the same edge.
  always @(posedge clk) begin
    list_result_t want;
    if (!rst_n) begin
      held_len = 0;
      due_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("result status %0d count %0d with no request outstanding",
                                    out_status, out_item_count));
        end else begin
          want = due_results.pop_front();
          if (out_status !== want.status) begin
            report_mismatch($sformatf("status %0d, expected %0d", out_status, want.status));
          end
          if (out_item_count !== want.item_count) begin
            report_mismatch($sformatf("item count %0d, expected %0d",
                                      out_item_count, want.item_count));
          end
        end
      end
      if (in_valid && !in_stall) begin
        want.status     = apply_request(in_operation, in_position, in_value);
        want.item_count = held_len[OCOUNT_W-1:0];
        due_results.push_back(want);
      end
    end
    mismatch_count <= errors;
    results_owed   <= due_results.size();
    list_length    <= held_len;
  end

endmodule

### test/tb_positional_list_store.sv
// Testbench top for the positional list store: clock, reset, request stimulus and result
// stall patterns, and the final verdict.
// Depends on pls_pkg, positional_list_store and pls_result_checker.
`timescale 1ns / 100ps

module tb_positional_list_store;
  import pls_pkg::*;

  // Operation code that the block does not use.
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
  localparam int CYCLE_LIMIT    = 800000;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int TAIL_CYCLES    = 2 * DEF_CAPACITY + 20;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic [OP_W-1:0]         in_operation;
  logic [POS_W-1:0]        in_position;
  logic signed [VAL_W-1:0] in_value;
  logic                    out_valid;
  logic                    out_stall;
  logic [STATUS_W-1:0]     out_status;
  logic [OCOUNT_W-1:0]     out_item_count;

  int  mismatches;
  int  owed;
  int  list_len;
  int  cycle_count;
  bit  quiet;
  int  send_idle_pct;
  int  holdoff_req;
  int  holdoff_done;

  logic signed [VAL_W-1:0] value_pool [8];
  logic [OP_W-1:0] ins_ops [3] = '{OP_INS_FRONT, OP_INS_BACK, OP_INS_POS};
  logic [OP_W-1:0] del_ops [4] = '{OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_POS, OP_DEL_VAL};

  positional_list_store #(
    .CAPACITY(DEF_CAPACITY)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_operation  (in_operation),
    .in_position   (in_position),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_item_count(out_item_count)
  );

  pls_result_checker #(
    .CAPACITY(DEF_CAPACITY)
  ) u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_operation  (in_operation),
    .in_position   (in_position),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_item_count(out_item_count),
    .mismatch_count(mismatches),
    .results_owed  (owed),
    .list_length   (list_len)
  );

  // Free-running clock with a 4 ns period.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Guard against a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_positional_list_store: FAIL");
      $finish;
    end
  end

  // Result side: random stall bursts, and a long hold-off whenever one is requested.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (holdoff_done != holdoff_req) begin
        holdoff_done++;
        out_stall <= 1'b1;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(0, 24)) @(posedge clk);
      end
    end
  end

  // Offer one item, hold it until accepted, then perhaps leave a gap.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                           input logic signed [VAL_W-1:0] v);
    in_valid     <= 1'b1;
    in_operation <= op;
    in_position  <= pos;
    in_value     <= v;
    do @(posedge clk); while (in_stall);
    if (!quiet && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // Stop offering until every outstanding result has arrived.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (owed != 0) @(posedge clk);
  endtask

  // A run of random requests; ins_pct sets how strongly the list grows.
  task automatic run_phase(input int n_items, input int ins_pct);
    logic [OP_W-1:0]         op;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] v;
    int                      r;
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(0, 99);
      if (r < ins_pct) op = ins_ops[$urandom_range(0, 2)];
      else if (r < 98) op = del_ops[$urandom_range(0, 3)];
      else op = OP_UNUSED;
      // Mostly positions near the live range, with its edges and the full range now and then.
      r = $urandom_range(0, 9);
      if (r < 7) pos = POS_W'($urandom_range(0, list_len + 2));
      else if (r < 9) pos = POS_W'(list_len + $urandom_range(0, 1));
      else pos = POS_W'($urandom_range(0, 255));
      // A small pool of values makes duplicates and matching deletes likely.
      if ($urandom_range(0, 1) == 0) v = value_pool[$urandom_range(0, 7)];
      else v = $urandom;
      send_item(op, pos, v);
    end
  endtask

  // Main stimulus sequence.
  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_operation <= OP_INS_FRONT;
    in_position  <= '0;
    in_value     <= '0;
    quiet         = 1'b0;
    send_idle_pct = 30;
    value_pool[0] = 32'sh8000_0000;
    value_pool[1] = 32'sh7fff_ffff;
    value_pool[2] = 32'sh0000_0000;
    value_pool[3] = -32'sd1;
    value_pool[4] = 32'sd1;
    value_pool[5] = $urandom;
    value_pool[6] = $urandom;
    value_pool[7] = $urandom;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Requests on an empty list.
    send_item(OP_DEL_FRONT, 8'd0, 32'sd0);
    send_item(OP_DEL_BACK, 8'd0, 32'sd0);
    send_item(OP_DEL_POS, 8'd3, 32'sd0);
    send_item(OP_DEL_VAL, 8'd0, 32'sd0);
    send_item(OP_INS_POS, 8'd0, 32'sd5);
    send_item(OP_INS_POS, 8'd2, 32'sd5);
    send_item(OP_UNUSED, 8'd255, -32'sd1);
    // Build a short list with the extreme values, through every kind of insert.
    send_item(OP_INS_POS, 8'd1, 32'sh7fff_ffff);
    send_item(OP_INS_FRONT, 8'd0, 32'sh8000_0000);
    send_item(OP_INS_BACK, 8'd0, -32'sd1);
    send_item(OP_INS_POS, 8'd4, 32'sd0);
    send_item(OP_INS_POS, 8'd2, 32'sd12345);
    // Out-of-range and zero positions against a populated list.
    send_item(OP_INS_POS, 8'd7, 32'sd9);
    send_item(OP_INS_POS, 8'd255, 32'sd9);
    send_item(OP_DEL_POS, 8'd0, 32'sd0);
    send_item(OP_DEL_POS, 8'd6, 32'sd0);
    send_item(OP_DEL_POS, 8'd255, 32'sd0);
    send_item(OP_DEL_VAL, 8'd0, 32'sd42);
    // Deletes of every kind until the list is empty again.
    send_item(OP_DEL_VAL, 8'd0, -32'sd1);
    send_item(OP_DEL_POS, 8'd2, 32'sd0);
    send_item(OP_DEL_FRONT, 8'd0, 32'sd0);
    send_item(OP_DEL_BACK, 8'd0, 32'sd0);
    send_item(OP_DEL_VAL, 8'd0, 32'sh7fff_ffff);
    send_item(OP_DEL_POS, 8'd1, 32'sd0);
    settle();

    // Fill past capacity, then keep offering while the result side holds off.
    send_idle_pct = 20;
    run_phase(110, 90);
    holdoff_req++;
    send_idle_pct = 0;
    run_phase(40, 50);
    settle();

    // Drain towards empty.
    send_idle_pct = 30;
    run_phase(110, 10);

    // Mixed phases with varying bias and idling.
    for (int p = 0; p < 8; p++) begin
      case ($urandom_range(0, 2))
        0: send_idle_pct = 0;
        1: send_idle_pct = 25;
        default: send_idle_pct = 50;
      endcase
      if (p == 4) holdoff_req++;
      case ($urandom_range(0, 2))
        0: run_phase($urandom_range(30, 60), 85);
        1: run_phase($urandom_range(30, 60), 50);
        default: run_phase($urandom_range(30, 60), 15);
      endcase
      if ($urandom_range(0, 2) == 0) settle();
    end

    // Final stretch at full rate on both sides.
    quiet = 1'b1;
    run_phase(100, 50);
    settle();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb_positional_list_store: PASS");
    end else begin
      $display("tb_positional_list_store: FAIL");
    end
    $finish;
  end

endmodule
